/* rtl/core/rfbhd_pkg.sv */
package rfbhd_pkg;

  localparam int TABLE_DEPTH_DEF = 8;

  localparam logic [15:0] BANNER_LEN  = 16'd12;
  localparam logic [31:0] SEQ_STEP    = 32'd12;
  localparam logic [9:0]  MAJOR_MAX   = 10'd49;
  localparam logic [9:0]  MINOR_LIMIT = 10'd200;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [2:0] {
    ST_NOT_BANNER      = 3'd0,
    ST_DECIDED_ALREADY = 3'd1,
    ST_RETRANS         = 3'd2,
    ST_STORED          = 3'd3,
    ST_FULL            = 3'd4,
    ST_DECIDED         = 3'd5
  } rfbhd_status_t;

  typedef enum logic [1:0] {
    DIR_NONE    = 2'd0,
    DIR_CLIENT  = 2'd1,
    DIR_SWAPPED = 2'd2
  } rfbhd_dir_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FINISH,
    S_EMIT
  } rfbhd_state_t;

  typedef enum logic [1:0] {
    NUM_SKIP,
    NUM_DIGITS,
    NUM_STOP
  } rfbhd_numph_t;

  typedef struct packed {
    logic [31:0] source_ip;
    logic [15:0] payload_length;
    logic [63:0] payload_head;
    logic [31:0] payload_tail;
    logic [31:0] sequence_req;
    logic [31:0] ack_number;
  } rfbhd_in_t;

  typedef struct packed {
    rfbhd_status_t status;
    rfbhd_dir_t    direction;
  } rfbhd_out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } rfbhd_cmd_t;

  typedef struct packed {
    logic skip_scan;
    logic scan_done;
  } rfbhd_sts_t;

  typedef struct packed {
    logic       neg;
    logic [9:0] val;
  } rfbhd_num_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // atoi over three bytes; the byte after them never extends the number
  function automatic rfbhd_num_t atoi3(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2);
    logic [7:0]   c [3];
    rfbhd_numph_t ph;
    rfbhd_num_t   r;
    logic         dig;
    c[0] = b0;
    c[1] = b1;
    c[2] = b2;
    ph   = NUM_SKIP;
    r    = '0;
    for (int i = 0; i < 3; i++) begin
      dig = c[i] >= CH_ZERO && c[i] <= CH_NINE;
      case (ph)
        NUM_SKIP: begin
          if (is_ws(c[i])) begin
            ph = NUM_SKIP;
          end else if (c[i] == CH_PLUS || c[i] == CH_MINUS) begin
            r.neg = (c[i] == CH_MINUS);
            ph    = NUM_DIGITS;
          end else if (dig) begin
            r.val = {6'd0, c[i][3:0]};
            ph    = NUM_DIGITS;
          end else begin
            ph = NUM_STOP;
          end
        end
        NUM_DIGITS: begin
          if (dig) begin
            r.val = 10'(r.val * 10'd10 + {6'd0, c[i][3:0]});
          end else begin
            ph = NUM_STOP;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic logic is_banner(input logic [15:0] len, input logic [63:0] head,
                                     input logic [31:0] tail);
    logic [7:0] b [12];
    rfbhd_num_t mj;
    rfbhd_num_t mn;
    logic       shape;
    for (int i = 0; i < 8; i++) b[i] = head[63-8*i -: 8];
    for (int i = 0; i < 4; i++) b[8+i] = tail[31-8*i -: 8];
    shape = len == BANNER_LEN && b[11] == CH_LF && b[7] == CH_DOT && b[3] == CH_SPACE &&
            (b[0] | CASE_BIT) == CH_R && (b[1] | CASE_BIT) == CH_F &&
            (b[2] | CASE_BIT) == CH_B;
    mj = atoi3(b[4], b[5], b[6]);
    mn = atoi3(b[8], b[9], b[10]);
    return shape && !mj.neg && mj.val != 10'd0 && mj.val <= MAJOR_MAX &&
           (mn.neg ? (mn.val == 10'd0) : (mn.val < MINOR_LIMIT));
  endfunction

endpackage

/* rtl/core/rfbhd_ram.sv */
module rfbhd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  clk,
  we,
  waddr,
  wdata,
  raddr,
  rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             we;
  input  logic [AW-1:0]    waddr;
  input  logic [WIDTH-1:0] wdata;
  input  logic [AW-1:0]    raddr;
  output logic [WIDTH-1:0] rdata;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/rfbhd_ctrl.sv */
module rfbhd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output rfbhd_pkg::rfbhd_cmd_t cmd,
  input  rfbhd_pkg::rfbhd_sts_t sts
);
  import rfbhd_pkg::*;

  rfbhd_state_t state_r;
  rfbhd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = sts.skip_scan ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        // last compare lands on the same edge that leaves this state
        cmd.step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/rfbhd_dp.sv */
module rfbhd_dp #(
  parameter int TABLE_DEPTH = rfbhd_pkg::TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rfbhd_pkg::rfbhd_cmd_t cmd,
  output rfbhd_pkg::rfbhd_sts_t sts,
  input  rfbhd_pkg::rfbhd_in_t  in_data,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_data,
  output rfbhd_pkg::rfbhd_out_t out_data
);
  import rfbhd_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  rfbhd_in_t   item_r, item_nxt;
  rfbhd_out_t  res_r, res_nxt;
  logic [31:0] client_ip_r, client_ip_nxt;
  logic [CW-1:0] client_cnt_r, client_cnt_nxt;
  logic [CW-1:0] server_cnt_r, server_cnt_nxt;
  logic        decided_r, decided_nxt;
  rfbhd_dir_t  dec_dir_r, dec_dir_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic        cmp_vld_r, cmp_vld_nxt;
  logic        own_hit_r, own_hit_nxt;
  rfbhd_dir_t  dir_hit_r, dir_hit_nxt;

  logic        own_client;
  logic [CW-1:0] own_cnt, other_cnt, limit;
  logic        banner;
  logic [31:0] client_rd, server_rd, own_rd, other_rd, other_p12;
  rfbhd_dir_t  on_eq, on_p12;
  logic        client_we, server_we;

  assign own_client = (item_r.source_ip == client_ip_r);
  assign own_cnt    = own_client ? client_cnt_r : server_cnt_r;
  assign other_cnt  = own_client ? server_cnt_r : client_cnt_r;
  assign limit      = (own_cnt > other_cnt) ? own_cnt : other_cnt;
  assign banner     = is_banner(item_r.payload_length, item_r.payload_head,
                                item_r.payload_tail);
  assign own_rd     = own_client ? client_rd : server_rd;
  assign other_rd   = own_client ? server_rd : client_rd;
  assign other_p12  = other_rd + SEQ_STEP;
  assign on_eq      = own_client ? DIR_SWAPPED : DIR_CLIENT;
  assign on_p12     = own_client ? DIR_CLIENT : DIR_SWAPPED;

  assign sts.skip_scan = decided_r | ~banner;
  assign sts.scan_done = (idx_r >= limit);
  assign out_data      = res_r;

  rfbhd_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_client_tab (
    .clk   (clk),
    .we    (client_we),
    .waddr (own_cnt[AW-1:0]),
    .wdata (item_r.sequence_req),
    .raddr (idx_r[AW-1:0]),
    .rdata (client_rd)
  );

  rfbhd_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_server_tab (
    .clk   (clk),
    .we    (server_we),
    .waddr (own_cnt[AW-1:0]),
    .wdata (item_r.sequence_req),
    .raddr (idx_r[AW-1:0]),
    .rdata (server_rd)
  );

  always_comb begin
    item_nxt       = item_r;
    res_nxt        = res_r;
    client_ip_nxt  = client_ip_r;
    client_cnt_nxt = client_cnt_r;
    server_cnt_nxt = server_cnt_r;
    decided_nxt    = decided_r;
    dec_dir_nxt    = dec_dir_r;
    idx_nxt        = idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    own_hit_nxt    = own_hit_r;
    dir_hit_nxt    = dir_hit_r;
    client_we      = 1'b0;
    server_we      = 1'b0;

    if (cfg_we) begin
      client_ip_nxt = cfg_data;
    end

    if (cmd.load) begin
      item_nxt    = in_data;
      idx_nxt     = '0;
      own_hit_nxt = 1'b0;
      dir_hit_nxt = DIR_NONE;
    end

    // both tables are read at the same index; own and other scans run together
    if (cmd.step && idx_r < limit) begin
      cmp_vld_nxt = 1'b1;
      cmp_idx_nxt = idx_r;
      idx_nxt     = idx_r + CW'(1);
    end

    if (cmp_vld_r) begin
      if (cmp_idx_r < own_cnt && own_rd == item_r.sequence_req) begin
        own_hit_nxt = 1'b1;
      end
      // keep the first matching entry of the other side
      if (dir_hit_r == DIR_NONE && cmp_idx_r < other_cnt) begin
        if (other_rd == item_r.ack_number) begin
          dir_hit_nxt = on_eq;
        end else if (other_p12 == item_r.ack_number) begin
          dir_hit_nxt = on_p12;
        end
      end
    end

    if (cmd.finish) begin
      res_nxt.direction = DIR_NONE;
      if (decided_r) begin
        res_nxt.status    = ST_DECIDED_ALREADY;
        res_nxt.direction = dec_dir_r;
      end else if (!banner) begin
        res_nxt.status = ST_NOT_BANNER;
      end else if (own_hit_r) begin
        res_nxt.status = ST_RETRANS;
      end else if (dir_hit_r != DIR_NONE) begin
        res_nxt.status    = ST_DECIDED;
        res_nxt.direction = dir_hit_r;
        decided_nxt       = 1'b1;
        dec_dir_nxt       = dir_hit_r;
        client_cnt_nxt    = '0;
        server_cnt_nxt    = '0;
      end else if (own_cnt >= CW'(TABLE_DEPTH)) begin
        res_nxt.status = ST_FULL;
      end else begin
        res_nxt.status = ST_STORED;
        if (own_client) begin
          client_we      = 1'b1;
          client_cnt_nxt = client_cnt_r + CW'(1);
        end else begin
          server_we      = 1'b1;
          server_cnt_nxt = server_cnt_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      client_ip_r  <= '0;
      client_cnt_r <= '0;
      server_cnt_r <= '0;
      decided_r    <= 1'b0;
      dec_dir_r    <= DIR_NONE;
      idx_r        <= '0;
      cmp_idx_r    <= '0;
      cmp_vld_r    <= 1'b0;
      own_hit_r    <= 1'b0;
      dir_hit_r    <= DIR_NONE;
    end else begin
      client_ip_r  <= client_ip_nxt;
      client_cnt_r <= client_cnt_nxt;
      server_cnt_r <= server_cnt_nxt;
      decided_r    <= decided_nxt;
      dec_dir_r    <= dec_dir_nxt;
      idx_r        <= idx_nxt;
      cmp_idx_r    <= cmp_idx_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      own_hit_r    <= own_hit_nxt;
      dir_hit_r    <= dir_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

endmodule

/* rtl/core/rfb_handshake_direction_detect.sv */
// RFB session direction detector.
// Input channel: present one TCP packet summary on in_data and raise start;
// the item is taken at a clock edge where start is high and busy is low.
// Result channel: out_valid strobes for one cycle with out_data (status and
// direction); the receiver cannot stall, so the result must be taken then.
// Config channel: cfg_data carries client_ip; it is written on an edge with
// cfg_valid and cfg_ready high. cfg_ready is high while the block is idle.
// Flow: a packet that is not a banner, or any packet once the direction
// is decided, passes from the check state straight to finish and emit. A banner scans
// both sequence tables in lockstep, one entry a cycle through the registered
// table read port, up to the larger of the two table fill counts (at most
// TABLE_DEPTH), before finish and emit.
// One item at a time: the next start is taken at the end of the cycle after
// the strobe, when the block is idle again.
// Reset (rst_n low, synchronous) clears client_ip, both fill counts and the
// decided flag; table contents are left as they are and only entries below
// the fill count are ever used in a compare.
module rfb_handshake_direction_detect #(
  parameter int TABLE_DEPTH = rfbhd_pkg::TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  rfbhd_pkg::rfbhd_in_t  in_data,
  output logic                  out_valid,
  output rfbhd_pkg::rfbhd_out_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [31:0]           cfg_data
);
  import rfbhd_pkg::*;

  rfbhd_cmd_t cmd;
  rfbhd_sts_t sts;
  logic       cfg_we;

  assign cfg_ready = ~busy;
  assign cfg_we    = cfg_valid & cfg_ready;

  rfbhd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  rfbhd_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

/* rtl/core/rfbhd_checker.sv */
module rfbhd_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input rfbhd_pkg::rfbhd_out_t out_data
);
  import rfbhd_pkg::*;

  // a result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held longer than one cycle");

  // an accepted item keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  a_decided_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_DECIDED ||
                   out_data.status == ST_DECIDED_ALREADY))
    |-> (out_data.direction == DIR_CLIENT || out_data.direction == DIR_SWAPPED))
    else $error("decided result without a direction");

  a_undecided_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_NOT_BANNER || out_data.status == ST_RETRANS ||
                   out_data.status == ST_STORED || out_data.status == ST_FULL))
    |-> (out_data.direction == DIR_NONE))
    else $error("direction set on an undecided result");

endmodule

bind rfb_handshake_direction_detect rfbhd_checker u_rfbhd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

/* verif/tb_rfb_handshake_direction_detect.sv */
module tb_rfb_handshake_direction_detect;
  timeunit 1ns;
  timeprecision 1ps;

  import rfbhd_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int CLIENT_SIDE = 0;
  localparam int SERVER_SIDE = 1;
  localparam int STALL_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       start;
  logic       busy;
  rfbhd_in_t  in_data;
  logic       out_valid;
  rfbhd_out_t out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [31:0] cfg_data;

  // shadow of the block: banner sequence tables, fill counts, decision
  logic [31:0] seq_tab [2][DEPTH];
  int unsigned seq_cnt [2];
  bit          settled;
  rfbhd_dir_t  settled_dir;
  logic [31:0] cfg_ip;

  rfbhd_out_t verdict_q [$];
  rfbhd_out_t want;
  int         mismatches;
  int         idle_cycles;
  int         gap_pct;

  rfb_handshake_direction_detect dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // atoi from pos to the end of the 12 payload bytes
  function automatic int parse_num(input logic [7:0] b [12], input int pos);
    int v;
    bit neg;
    v   = 0;
    neg = 1'b0;
    while (pos < 12 && (b[pos] == CH_SPACE || (b[pos] >= CH_TAB && b[pos] <= CH_CR)))
      pos++;
    if (pos < 12 && (b[pos] == CH_PLUS || b[pos] == CH_MINUS)) begin
      neg = b[pos] == CH_MINUS;
      pos++;
    end
    while (pos < 12 && b[pos] >= CH_ZERO && b[pos] <= CH_NINE) begin
      v = v * 10 + int'(b[pos] - CH_ZERO);
      pos++;
    end
    return neg ? -v : v;
  endfunction

  function automatic bit looks_like_banner(input rfbhd_in_t p);
    logic [7:0] b [12];
    int major;
    int minor;
    for (int i = 0; i < 8; i++) b[i] = p.payload_head[63 - 8*i -: 8];
    for (int i = 0; i < 4; i++) b[8+i] = p.payload_tail[31 - 8*i -: 8];
    if (p.payload_length != BANNER_LEN) return 1'b0;
    if (b[11] != CH_LF || b[7] != CH_DOT || b[3] != CH_SPACE) return 1'b0;
    if ((b[0] | CASE_BIT) != CH_R || (b[1] | CASE_BIT) != CH_F || (b[2] | CASE_BIT) != CH_B)
      return 1'b0;
    major = parse_num(b, 4);
    minor = parse_num(b, 8);
    return major >= 1 && major <= int'(MAJOR_MAX) && minor >= 0 && minor < int'(MINOR_LIMIT);
  endfunction

  function automatic rfbhd_out_t track_packet(input rfbhd_in_t p);
    rfbhd_out_t r;
    int         own;
    int         oth;
    rfbhd_dir_t hit;
    r.status    = ST_NOT_BANNER;
    r.direction = DIR_NONE;
    hit         = DIR_NONE;
    if (settled) begin
      r.status    = ST_DECIDED_ALREADY;
      r.direction = settled_dir;
      return r;
    end
    if (!looks_like_banner(p)) return r;
    own = (p.source_ip == cfg_ip) ? CLIENT_SIDE : SERVER_SIDE;
    oth = 1 - own;
    for (int i = 0; i < int'(seq_cnt[own]); i++) begin
      if (seq_tab[own][i] == p.sequence_req) begin
        r.status = ST_RETRANS;
        return r;
      end
    end
    // first entry of the other side that matches either rule wins
    for (int i = 0; i < int'(seq_cnt[oth]) && hit == DIR_NONE; i++) begin
      if (seq_tab[oth][i] == p.ack_number)
        hit = (own == CLIENT_SIDE) ? DIR_SWAPPED : DIR_CLIENT;
      else if (seq_tab[oth][i] + SEQ_STEP == p.ack_number)
        hit = (own == CLIENT_SIDE) ? DIR_CLIENT : DIR_SWAPPED;
    end
    if (hit != DIR_NONE) begin
      settled     = 1'b1;
      settled_dir = hit;
      seq_cnt[0]  = 0;
      seq_cnt[1]  = 0;
      r.status    = ST_DECIDED;
      r.direction = hit;
    end else if (seq_cnt[own] >= DEPTH) begin
      r.status = ST_FULL;
    end else begin
      seq_tab[own][seq_cnt[own]] = p.sequence_req;
      seq_cnt[own]++;
      r.status = ST_STORED;
    end
    return r;
  endfunction

  // random ack that cannot settle the direction
  function automatic logic [31:0] quiet_ack();
    logic [31:0] a;
    bit          hit;
    do begin
      a   = $urandom;
      hit = 1'b0;
      for (int s = 0; s < 2; s++)
        for (int i = 0; i < int'(seq_cnt[s]); i++)
          if (a == seq_tab[s][i] || a == seq_tab[s][i] + SEQ_STEP) hit = 1'b1;
    end while (hit);
    return a;
  endfunction

  function automatic logic [23:0] num_text(input int n);
    logic [23:0] t;
    t = {CH_ZERO + 8'(n / 100), CH_ZERO + 8'((n / 10) % 10), CH_ZERO + 8'(n % 10)};
    case ($urandom_range(2))
      0: ;
      1: begin
        if (n < 100) t[23:16] = CH_SPACE;
        if (n < 10) t[15:8] = CH_SPACE;
      end
      default: if (n < 100) t[23:16] = CH_PLUS;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] odd_char();
    int pick;
    pick = $urandom_range(15);
    case (pick)
      10: return CH_SPACE;
      11: return CH_TAB;
      12: return CH_PLUS;
      13: return CH_MINUS;
      14: return "x";
      15: return 8'($urandom);
      default: return CH_ZERO + 8'(pick);
    endcase
  endfunction

  function automatic rfbhd_in_t banner_pkt(input logic [31:0] src, input logic [23:0] mj,
                                           input logic [23:0] mn, input logic [31:0] seq,
                                           input logic [31:0] ack);
    rfbhd_in_t p;
    p.source_ip      = src;
    p.payload_length = BANNER_LEN;
    p.payload_head   = {"RFB ", mj, CH_DOT};
    p.payload_tail   = {mn, CH_LF};
    p.sequence_req   = seq;
    p.ack_number     = ack;
    return p;
  endfunction

  function automatic rfbhd_in_t random_banner(input logic [31:0] src, input logic [31:0] seq);
    rfbhd_in_t   p;
    logic [23:0] mj;
    logic [23:0] mn;
    if ($urandom_range(4) != 0) begin
      mj = num_text($urandom_range(0, 55));
      mn = num_text($urandom_range(0, 210));
    end else begin
      mj = {odd_char(), odd_char(), odd_char()};
      mn = {odd_char(), odd_char(), odd_char()};
    end
    p = banner_pkt(src, mj, mn, seq, quiet_ack());
    // flip letter case at random
    p.payload_head[61] = 1'($urandom_range(1));
    p.payload_head[53] = 1'($urandom_range(1));
    p.payload_head[45] = 1'($urandom_range(1));
    return p;
  endfunction

  function automatic logic [31:0] pick_source();
    case ($urandom_range(3))
      0, 1: return cfg_ip;
      2: return ~cfg_ip;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_packet(input rfbhd_in_t pkt);
    @(negedge clk);
    // hold until the block is idle so that a gap is seen by it
    while (busy !== 1'b0) @(negedge clk);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < gap_pct);
    end
    start   <= 1'b1;
    in_data <= pkt;
    do @(posedge clk); while (busy !== 1'b0);
    verdict_q.push_back(track_packet(pkt));
  endtask

  task automatic write_client_ip(input logic [31:0] ip);
    @(negedge clk);
    start <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= ip;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_ip = ip;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    rfbhd_in_t   p;
    logic [31:0] src;
    logic [95:0] body;
    int          side;
    int          roll;
    int          bitpos;
    src  = pick_source();
    side = (src == cfg_ip) ? CLIENT_SIDE : SERVER_SIDE;
    roll = $urandom_range(99);
    if (roll < 45) begin
      p = random_banner(src, $urandom);
    end else if (roll < 60) begin
      if (seq_cnt[side] != 0)
        p = random_banner(src, seq_tab[side][$urandom_range(seq_cnt[side] - 1)]);
      else
        p = random_banner(src, $urandom);
    end else if (roll < 75) begin
      p = random_banner(src, $urandom);
      if ($urandom_range(3) == 0) begin
        p.payload_length = 16'($urandom);
      end else begin
        body         = {p.payload_head, p.payload_tail};
        bitpos       = $urandom_range(95);
        body[bitpos] = ~body[bitpos];
        {p.payload_head, p.payload_tail} = body;
      end
    end else begin
      p.source_ip      = src;
      p.payload_length = $urandom_range(1) ? BANNER_LEN : 16'($urandom);
      p.payload_head   = {$urandom, $urandom};
      p.payload_tail   = $urandom;
      p.sequence_req   = $urandom;
      p.ack_number     = quiet_ack();
    end
    send_packet(p);
  endtask

  task automatic test_non_banners();
    rfbhd_in_t p;
    p = '0;
    send_packet(p);
    p = '1;
    send_packet(p);
    p = banner_pkt(32'h0, "003", "008", $urandom, 32'h0);
    p.payload_length = 16'd11;
    send_packet(p);
    p.payload_length = 16'd13;
    send_packet(p);
    p.payload_length = 16'hFFFF;
    p.ack_number     = 32'hFFFF_FFFF;
    send_packet(p);
    p = banner_pkt(32'hFFFF_FFFF, "003", "008", $urandom, $urandom);
    p.payload_head[39:32] = CH_TAB;
    send_packet(p);
    p = banner_pkt(32'hFFFF_FFFF, "003", "008", $urandom, $urandom);
    p.payload_head[7:0] = ",";
    send_packet(p);
    p = banner_pkt(32'h0, "003", "008", $urandom, $urandom);
    p.payload_tail[7:0] = CH_CR;
    send_packet(p);
    p = banner_pkt(32'h0, "003", "008", $urandom, $urandom);
    p.payload_head[55:48] = "G";
    send_packet(p);
  endtask

  // client is address 0 here, the server side uses all ones
  task automatic test_version_fields();
    rfbhd_in_t p;
    send_packet(banner_pkt(32'h0, "003", "008", 32'h0, quiet_ack()));
    p = banner_pkt(32'hFFFF_FFFF, "003", "003", 32'hFFFF_FFF8, quiet_ack());
    p.payload_head[63:40] = "rfb";
    send_packet(p);
    p = banner_pkt(32'h0, " 49", "199", 32'h1, quiet_ack());
    p.payload_head[63:40] = "RfB";
    send_packet(p);
    send_packet(banner_pkt(32'h0, "050", "000", $urandom, quiet_ack()));
    send_packet(banner_pkt(32'h0, "000", "009", $urandom, quiet_ack()));
    send_packet(banner_pkt(32'hFFFF_FFFF, "001", "200", $urandom, quiet_ack()));
    send_packet(banner_pkt(32'hFFFF_FFFF, "+12", "-0 ", 32'hFFFF_FFFF, quiet_ack()));
    send_packet(banner_pkt(32'h0, "-01", "005", $urandom, quiet_ack()));
    // minor that is whitespace up to the end of the payload reads as zero
    send_packet(banner_pkt(32'h0, "\t\t7", "   ", $urandom, quiet_ack()));
    send_packet(banner_pkt(32'hFFFF_FFFF, "1x2", "abc", $urandom, quiet_ack()));
    send_packet(banner_pkt(32'hFFFF_FFFF, "...", "000", $urandom, quiet_ack()));
    send_packet(banner_pkt(32'hFFFF_FFFF, "002", "-01", $urandom, quiet_ack()));
    send_packet(banner_pkt(32'h0, " \n5", "001", $urandom, quiet_ack()));
  endtask

  task automatic test_retransmission();
    send_packet(banner_pkt(32'h0, "003", "008", 32'h0, quiet_ack()));
    send_packet(banner_pkt(32'hFFFF_FFFF, "003", "003", 32'hFFFF_FFF8, quiet_ack()));
  endtask

  task automatic test_random_traffic();
    for (int c = 0; c < 4; c++) begin
      write_client_ip(c == 1 ? 32'hFFFF_FFFF : 32'($urandom));
      // one chunk runs back to back with no gaps
      gap_pct = (c == 2) ? 0 : 17;
      for (int n = 0; n < 150; n++) random_item();
    end
    gap_pct = 17;
  endtask

  task automatic test_decision();
    int          own;
    int          oth;
    logic [31:0] src;
    logic [31:0] hit_ack;
    own = $urandom_range(1);
    if (seq_cnt[1 - own] == 0) own = 1 - own;
    oth     = 1 - own;
    src     = (own == CLIENT_SIDE) ? cfg_ip : ~cfg_ip;
    hit_ack = seq_tab[oth][$urandom_range(seq_cnt[oth] - 1)];
    if ($urandom_range(1)) hit_ack = hit_ack + SEQ_STEP;
    // a resent banner stays a retransmission even when its ack matches
    if (seq_cnt[own] != 0)
      send_packet(banner_pkt(src, "003", "008",
                             seq_tab[own][$urandom_range(seq_cnt[own] - 1)], hit_ack));
    send_packet(banner_pkt(src, "003", "007", $urandom, hit_ack));
  endtask

  task automatic test_after_decision();
    rfbhd_in_t p;
    for (int n = 0; n < 10; n++) random_item();
    write_client_ip($urandom);
    p = '0;
    send_packet(p);
    p = '1;
    send_packet(p);
    send_packet(banner_pkt(cfg_ip, "003", "008", $urandom, $urandom));
    for (int n = 0; n < 6; n++) random_item();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result with none expected: status %0d direction %0d", $time,
                 out_data.status, out_data.direction);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data.status);
          mismatches++;
        end
        if (out_data.direction !== want.direction) begin
          $display("%0t: direction expected %0d actual %0d", $time, want.direction,
                   out_data.direction);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_rfb_handshake_direction_detect NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    cfg_ip      = '0;
    seq_cnt[0]  = 0;
    seq_cnt[1]  = 0;
    settled     = 1'b0;
    settled_dir = DIR_NONE;
    mismatches  = 0;
    idle_cycles = 0;
    gap_pct     = 17;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_client_ip(32'h0);
    test_non_banners();
    test_version_fields();
    test_retransmission();
    test_random_traffic();
    test_decision();
    test_after_decision();

    @(negedge clk);
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("tb_rfb_handshake_direction_detect OK");
    else
      $display("tb_rfb_handshake_direction_detect NOT OK");
    $finish;
  end

endmodule
